FILE: design/mcss_pkg.sv
// ----------------------------------------------------------------------------
// Motor command stack sequencer package
// Shared types and constants for the sequencer controller, datapath and top.
// ----------------------------------------------------------------------------
package mcss_pkg;

   // Field widths fixed by the command and result formats.
   localparam int DIR_W      = 2;
   localparam int VEL_W      = 8;
   localparam int STEPS_W    = 8;
   localparam int DUTY_W     = 10;
   localparam int DUR_MS_W   = 15;
   localparam int LEVEL_W    = 4;
   localparam int LIMIT_W    = 7;
   localparam int SCALE_W    = 4;
   localparam int MS_STEP_W  = 7;

   // Configuration port geometry.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Register indexes, taken from byte address bits [3:2].
   localparam logic [1:0] IDX_VELOCITY_LIMIT = 2'd0;
   localparam logic [1:0] IDX_DUTY_SCALE     = 2'd1;
   localparam logic [1:0] IDX_MS_PER_STEP    = 2'd2;

   // Register reset values.
   localparam logic [LIMIT_W-1:0]   VELOCITY_LIMIT_RST = 7'd100;
   localparam logic [SCALE_W-1:0]   DUTY_SCALE_RST     = 4'd10;
   localparam logic [MS_STEP_W-1:0] MS_PER_STEP_RST    = 7'd100;

   // Largest compare value and largest elapsed time.
   localparam logic [DUTY_W-1:0]   DUTY_MAX    = 10'd1000;
   localparam logic [DUR_MS_W-1:0] ELAPSED_MAX = 15'h7FFF;

   // Item kinds.
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // Directions.
   localparam logic [DIR_W-1:0] DIR_FORWARD  = 2'd0;
   localparam logic [DIR_W-1:0] DIR_BACKWARD = 2'd1;
   localparam logic [DIR_W-1:0] DIR_RIGHT    = 2'd2;
   localparam logic [DIR_W-1:0] DIR_LEFT     = 2'd3;

   // One stored motion command.
   typedef struct packed {
      logic [DIR_W-1:0]    direction;
      logic [DUTY_W-1:0]   duty;
      logic [DUR_MS_W-1:0] duration_ms;
   } stack_entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;   // request accepted: capture it and start the stack read
      logic exec;   // carry out the captured request and fill the result
   } dp_cmd_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } ctrl_state_type;

endpackage

FILE: design/mcss_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module mcss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/mcss_ctrl.sv
// ----------------------------------------------------------------------------
// Sequencer controller
// Handshake control: accepts a request, runs it in the execute state, holds the result.
// ----------------------------------------------------------------------------
module mcss_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output mcss_pkg::dp_cmd_type dp_cmd
);
   import mcss_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           accept;

   // A new request waits during reset, while one is in work or a result cannot leave.
   assign req_stall = reset || (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The result register fills on execute and empties when taken.
   assign rsp_valid_in = (state_ff == ST_EXEC) ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign dp_cmd.load = accept;
   assign dp_cmd.exec = (state_ff == ST_EXEC);
   assign rsp_valid   = rsp_valid_ff;

`ifndef SYNTHESIS
   // An accepted request is executed in the next cycle.
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_EXEC))
      else $error("accepted request was not executed next cycle");

   // Execution always leaves a result waiting.
   a_exec_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |=> rsp_valid_ff)
      else $error("execution did not produce a result");

   // A result is never overwritten while it is stalled.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |-> !(rsp_valid_ff && rsp_stall))
      else $error("result overwritten while stalled");
`endif

endmodule

FILE: design/mcss_dp.sv
// ----------------------------------------------------------------------------
// Sequencer datapath
// Configuration registers, stack pointer, active command and result registers.
// ----------------------------------------------------------------------------
module mcss_dp #(
   parameter int STACK_DEPTH = 8,
   parameter int ADDR_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
   parameter int COUNT_W = $clog2(STACK_DEPTH + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mcss_pkg::dp_cmd_type                dp_cmd,
   // Request fields.
   input  logic                                req_cmd,
   input  logic [mcss_pkg::DIR_W-1:0]          req_direction,
   input  logic [mcss_pkg::VEL_W-1:0]          req_velocity_percent,
   input  logic [mcss_pkg::STEPS_W-1:0]        req_duration_steps,
   // Configuration port.
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [mcss_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [mcss_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [mcss_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready,
   // Stack memory.
   output logic                                ram_wr_en,
   output logic [ADDR_W-1:0]                   ram_wr_addr,
   output mcss_pkg::stack_entry_type           ram_wr_data,
   output logic                                ram_rd_en,
   output logic [ADDR_W-1:0]                   ram_rd_addr,
   input  mcss_pkg::stack_entry_type           ram_rd_data,
   // Result fields.
   output logic [mcss_pkg::DUTY_W-1:0]         rsp_timer_a_ch1_duty,
   output logic [mcss_pkg::DUTY_W-1:0]         rsp_timer_a_ch2_duty,
   output logic [mcss_pkg::DUTY_W-1:0]         rsp_timer_b_ch1_duty,
   output logic [mcss_pkg::DUTY_W-1:0]         rsp_timer_b_ch2_duty,
   output logic                                rsp_command_done,
   output logic                                rsp_running,
   output logic [mcss_pkg::LEVEL_W-1:0]        rsp_stack_level,
   output logic                                rsp_push_dropped
);
   import mcss_pkg::*;

   localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(STACK_DEPTH);

   // Configuration registers.
   logic [LIMIT_W-1:0]   velocity_limit_ff;
   logic [SCALE_W-1:0]   duty_scale_ff;
   logic [MS_STEP_W-1:0] ms_per_step_ff;
   logic                 csr_write;

   // Captured request.
   logic                 cmd_ff;
   logic [DIR_W-1:0]     dir_ff;
   logic [VEL_W-1:0]     vel_ff;
   logic [STEPS_W-1:0]   steps_ff;

   // Sequencer state.
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 active_ff, active_in;
   logic [DIR_W-1:0]     act_dir_ff, act_dir_in;
   logic [DUTY_W-1:0]    act_duty_ff, act_duty_in;
   logic [DUR_MS_W-1:0]  act_dur_ff, act_dur_in;
   logic [DUR_MS_W-1:0]  elapsed_ff, elapsed_in;

   // Push arithmetic.
   logic [LIMIT_W-1:0]         vel_clamped;
   logic [LIMIT_W+SCALE_W-1:0] duty_raw;
   logic [DUTY_W-1:0]          duty_sat;
   logic [DUR_MS_W-1:0]        dur_ms;

   // Result next values.
   logic                 done_in, dropped_in;
   logic [DUTY_W-1:0]    a1_in, a2_in, b1_in, b2_in;
   logic [DUR_MS_W-1:0]  elapsed_inc;

   // Result registers.
   logic [DUTY_W-1:0]    a1_ff, a2_ff, b1_ff, b2_ff;
   logic                 done_ff, running_ff, dropped_ff;
   logic [LEVEL_W-1:0]   level_ff;

   // Configuration write and read.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         velocity_limit_ff <= VELOCITY_LIMIT_RST;
         duty_scale_ff     <= DUTY_SCALE_RST;
         ms_per_step_ff    <= MS_PER_STEP_RST;
      end else if (csr_write) begin
         case (paddr[3:2])
            IDX_VELOCITY_LIMIT: velocity_limit_ff <= pwdata[LIMIT_W-1:0];
            IDX_DUTY_SCALE:     duty_scale_ff     <= pwdata[SCALE_W-1:0];
            IDX_MS_PER_STEP:    ms_per_step_ff    <= pwdata[MS_STEP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         IDX_VELOCITY_LIMIT: prdata = CSR_DATA_W'(velocity_limit_ff);
         IDX_DUTY_SCALE:     prdata = CSR_DATA_W'(duty_scale_ff);
         IDX_MS_PER_STEP:    prdata = CSR_DATA_W'(ms_per_step_ff);
         default:            prdata = '0;
      endcase
   end

   // Capture the request as it is accepted.
   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         cmd_ff   <= req_cmd;
         dir_ff   <= req_direction;
         vel_ff   <= req_velocity_percent;
         steps_ff <= req_duration_steps;
      end
   end

   // The top of the stack is read while the request is accepted.
   assign ram_rd_en   = dp_cmd.load;
   assign ram_rd_addr = ADDR_W'(count_ff - COUNT_W'(1));

   // Clamp, scale and saturate the pushed velocity; scale the duration.
   assign vel_clamped = (vel_ff > VEL_W'(velocity_limit_ff)) ? velocity_limit_ff
                                                             : vel_ff[LIMIT_W-1:0];
   assign duty_raw = vel_clamped * duty_scale_ff;
   assign duty_sat = (duty_raw > (LIMIT_W+SCALE_W)'(DUTY_MAX)) ? DUTY_MAX
                                                               : DUTY_W'(duty_raw);
   assign dur_ms   = DUR_MS_W'(steps_ff) * DUR_MS_W'(ms_per_step_ff);

   assign ram_wr_data.direction   = dir_ff;
   assign ram_wr_data.duty        = duty_sat;
   assign ram_wr_data.duration_ms = dur_ms;
   assign ram_wr_addr = ADDR_W'(count_ff);
   assign ram_wr_en   = dp_cmd.exec && (cmd_ff == CMD_PUSH) && (count_ff < DEPTH_C);

   assign elapsed_inc = (elapsed_ff != ELAPSED_MAX) ? (elapsed_ff + DUR_MS_W'(1))
                                                    : elapsed_ff;

   // Push, pop and timing of the active command.
   always_comb begin
      count_in    = count_ff;
      active_in   = active_ff;
      act_dir_in  = act_dir_ff;
      act_duty_in = act_duty_ff;
      act_dur_in  = act_dur_ff;
      elapsed_in  = elapsed_ff;
      done_in     = 1'b0;
      dropped_in  = 1'b0;
      if (cmd_ff == CMD_PUSH) begin
         if (count_ff < DEPTH_C) begin
            count_in = count_ff + COUNT_W'(1);
         end else begin
            dropped_in = 1'b1;
         end
      end else if (!active_ff) begin
         if (count_ff != '0) begin
            count_in    = count_ff - COUNT_W'(1);
            act_dir_in  = ram_rd_data.direction;
            act_duty_in = ram_rd_data.duty;
            act_dur_in  = ram_rd_data.duration_ms;
            elapsed_in  = '0;
            active_in   = 1'b1;
         end
      end else begin
         elapsed_in = elapsed_inc;
         if (elapsed_inc >= act_dur_ff) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   // Channel selection by direction.
   always_comb begin
      a1_in = '0;
      a2_in = '0;
      b1_in = '0;
      b2_in = '0;
      if (active_in) begin
         case (act_dir_in)
            DIR_FORWARD: begin
               a1_in = act_duty_in;
               b2_in = act_duty_in;
            end
            DIR_BACKWARD: begin
               a2_in = act_duty_in;
               b1_in = act_duty_in;
            end
            DIR_RIGHT: begin
               a1_in = act_duty_in;
               b1_in = act_duty_in;
            end
            default: begin
               a2_in = act_duty_in;
               b2_in = act_duty_in;
            end
         endcase
      end
   end

   // Sequencer state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         active_ff   <= 1'b0;
         act_dir_ff  <= '0;
         act_duty_ff <= '0;
         act_dur_ff  <= '0;
         elapsed_ff  <= '0;
      end else if (dp_cmd.exec) begin
         count_ff    <= count_in;
         active_ff   <= active_in;
         act_dir_ff  <= act_dir_in;
         act_duty_ff <= act_duty_in;
         act_dur_ff  <= act_dur_in;
         elapsed_ff  <= elapsed_in;
      end
   end

   // Result registers, held while the result waits.
   always_ff @(posedge clock) begin
      if (dp_cmd.exec) begin
         a1_ff      <= a1_in;
         a2_ff      <= a2_in;
         b1_ff      <= b1_in;
         b2_ff      <= b2_in;
         done_ff    <= done_in;
         running_ff <= active_in;
         level_ff   <= LEVEL_W'(count_in);
         dropped_ff <= dropped_in;
      end
   end

   assign rsp_timer_a_ch1_duty = a1_ff;
   assign rsp_timer_a_ch2_duty = a2_ff;
   assign rsp_timer_b_ch1_duty = b1_ff;
   assign rsp_timer_b_ch2_duty = b2_ff;
   assign rsp_command_done     = done_ff;
   assign rsp_running          = running_ff;
   assign rsp_stack_level      = level_ff;
   assign rsp_push_dropped     = dropped_ff;

`ifndef SYNTHESIS
   // The stack count never exceeds the stack depth.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("stack count beyond depth");

   // A pop that starts a command always begins with zero elapsed time.
   a_start_zero: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.exec && !active_ff && active_in) |=> (elapsed_ff == '0))
      else $error("started command with nonzero elapsed time");

   // The stack is written only on a push into a stack with room.
   a_write_room: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |=> (count_ff == $past(count_ff) + COUNT_W'(1)))
      else $error("stack write without matching count increment");
`endif

endmodule

FILE: design/motor_command_stack_sequencer.sv
// ----------------------------------------------------------------------------
// Motor command stack sequencer
// Stacks motion commands and drives four motor compare channels per tick.
// ----------------------------------------------------------------------------
// Usage:
// The request channel carries either a push (req_cmd low) with direction,
// velocity and duration, or a one millisecond tick (req_cmd high). Each
// request yields exactly one response with the four channel duties, the
// done pulse, the running flag, the stack level and the drop flag.
// A request is accepted when req_valid is high and req_stall is low. The
// response is registered after the execute state that follows acceptance
// and stays until rsp_stall is low. One request is in work at a time: no
// new request is taken until the last has executed, which waits on the
// registered stack read. While a response is stalled, req_stall stays high.
// Configuration registers sit at byte addresses 0, 4 and 8 of the psel
// port; write them only while no request is in work.
// A synchronous reset empties the stack, stops the active command and
// restores the register defaults; the result registers and the stack memory are not cleared.
// ----------------------------------------------------------------------------
module motor_command_stack_sequencer #(
   parameter int STACK_DEPTH = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel.
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_cmd,
   input  logic [mcss_pkg::DIR_W-1:0]         req_direction,
   input  logic [mcss_pkg::VEL_W-1:0]         req_velocity_percent,
   input  logic [mcss_pkg::STEPS_W-1:0]       req_duration_steps,
   // Response channel.
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [mcss_pkg::DUTY_W-1:0]        rsp_timer_a_ch1_duty,
   output logic [mcss_pkg::DUTY_W-1:0]        rsp_timer_a_ch2_duty,
   output logic [mcss_pkg::DUTY_W-1:0]        rsp_timer_b_ch1_duty,
   output logic [mcss_pkg::DUTY_W-1:0]        rsp_timer_b_ch2_duty,
   output logic                               rsp_command_done,
   output logic                               rsp_running,
   output logic [mcss_pkg::LEVEL_W-1:0]       rsp_stack_level,
   output logic                               rsp_push_dropped,
   // Configuration port.
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [mcss_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [mcss_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [mcss_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready
);
   import mcss_pkg::*;

   localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   dp_cmd_type          dp_cmd;
   logic                ram_wr_en;
   logic [ADDR_W-1:0]   ram_wr_addr;
   stack_entry_type     ram_wr_data;
   logic                ram_rd_en;
   logic [ADDR_W-1:0]   ram_rd_addr;
   stack_entry_type     ram_rd_data;

   // Handshake controller.
   mcss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_cmd    (dp_cmd)
   );

   // Datapath with configuration registers.
   mcss_dp #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .dp_cmd               (dp_cmd),
      .req_cmd              (req_cmd),
      .req_direction        (req_direction),
      .req_velocity_percent (req_velocity_percent),
      .req_duration_steps   (req_duration_steps),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .prdata               (prdata),
      .pready               (pready),
      .ram_wr_en            (ram_wr_en),
      .ram_wr_addr          (ram_wr_addr),
      .ram_wr_data          (ram_wr_data),
      .ram_rd_en            (ram_rd_en),
      .ram_rd_addr          (ram_rd_addr),
      .ram_rd_data          (ram_rd_data),
      .rsp_timer_a_ch1_duty (rsp_timer_a_ch1_duty),
      .rsp_timer_a_ch2_duty (rsp_timer_a_ch2_duty),
      .rsp_timer_b_ch1_duty (rsp_timer_b_ch1_duty),
      .rsp_timer_b_ch2_duty (rsp_timer_b_ch2_duty),
      .rsp_command_done     (rsp_command_done),
      .rsp_running          (rsp_running),
      .rsp_stack_level      (rsp_stack_level),
      .rsp_push_dropped     (rsp_push_dropped)
   );

   // Command stack storage.
   mcss_ram #(
      .WIDTH (DIR_W + DUTY_W + DUR_MS_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule
